[hdl/fcc_pkg.sv]
// ----------------------------------------------------------------------------
// fcc_pkg: shared types, constants and a function for the frame checker
// Result layout, status codes and the byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
package fcc_pkg;

    // Frame layout
    localparam int unsigned HdrBytes     = 6;
    localparam int unsigned TrailerBytes = 4;
    localparam int unsigned CountWidth   = 17;

    localparam logic [CountWidth-1:0] COUNT_MAX   = {CountWidth{1'b1}};
    localparam logic [CountWidth-1:0] MIN_FRAME   = CountWidth'(HdrBytes + TrailerBytes);
    localparam logic [CountWidth-1:0] HDR_LEN     = CountWidth'(HdrBytes);
    localparam logic [CountWidth-1:0] TRAILER_LEN = CountWidth'(TrailerBytes);

    // Reflected CRC-32
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // Configuration reset value
    localparam logic [7:0] VERSION_RESET = 8'd1;

    // Status codes
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_MALFORMED   = 2'd1,
        STATUS_BAD_VERSION = 2'd2,
        STATUS_BAD_CRC     = 2'd3
    } status_t;

    // One result; status sits in the low bits
    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  frame_id;
        logic [7:0]  opcode;
        logic [7:0]  frame_type;
        status_t     status;
    } result_t;

    localparam int unsigned ResultWidth = $bits(result_t);
    localparam int unsigned OutDataWidth = ((ResultWidth + 7) / 8) * 8;

    // One byte through the reflected CRC-32, LSB first
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

[hdl/fcc_frame_tracker.sv]
// ----------------------------------------------------------------------------
// fcc_frame_tracker: input register and per-frame state
// Holds one received byte, then updates count, header, trailer window and CRC
// and builds the status on the final byte of a frame.
// ----------------------------------------------------------------------------
module fcc_frame_tracker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [7:0]      cfg_wr_data,
    input  logic            in_valid,
    input  logic [7:0]      in_data,
    input  logic            in_last,
    output logic            in_ready,
    output logic            res_valid,
    output fcc_pkg::result_t res_data,
    input  logic            res_ready
);

    logic                            in_valid_reg;
    logic [7:0]                      in_data_reg;
    logic                            in_last_reg;
    logic [7:0]                      version_reg;
    logic [fcc_pkg::CountWidth-1:0]  count_reg;
    logic [fcc_pkg::CountWidth-1:0]  count_next;
    logic [47:0]                     header_reg;
    logic [47:0]                     header_next;
    logic [31:0]                     crc_reg;
    logic [31:0]                     crc_next;
    logic [31:0]                     trailer_reg;
    logic [31:0]                     trailer_next;
    logic                            advance;
    logic [fcc_pkg::CountWidth-1:0]  expect_len;
    fcc_pkg::status_t                status;

    // Byte leaves the input register unless a result is blocked
    assign advance  = in_valid_reg && (!in_last_reg || res_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid) begin
            in_data_reg <= in_data;
            in_last_reg <= in_last;
        end
    end

    // Expected version register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            version_reg <= fcc_pkg::VERSION_RESET;
        end
        else if (cfg_wr_en) begin
            version_reg <= cfg_wr_data;
        end
    end

    // Per-frame state update for the byte in the input register
    always_comb begin
        header_next = header_reg;
        case (count_reg)
            17'd0:   header_next[7:0]   = in_data_reg;
            17'd1:   header_next[15:8]  = in_data_reg;
            17'd2:   header_next[23:16] = in_data_reg;
            17'd3:   header_next[31:24] = in_data_reg;
            17'd4:   header_next[39:32] = in_data_reg;
            17'd5:   header_next[47:40] = in_data_reg;
            default: header_next = header_reg;
        endcase

        // CRC lags the trailer window by four bytes
        if (count_reg >= fcc_pkg::TRAILER_LEN) begin
            crc_next = fcc_pkg::crc_feed(crc_reg, trailer_reg[7:0]);
        end
        else begin
            crc_next = crc_reg;
        end
        trailer_next = {in_data_reg, trailer_reg[31:8]};

        count_next = (count_reg != fcc_pkg::COUNT_MAX) ?
                     count_reg + 1'b1 : fcc_pkg::COUNT_MAX;
    end

    // Checks in priority order: length, version, CRC
    assign expect_len = {1'b0, header_next[47:32]} + fcc_pkg::MIN_FRAME;

    always_comb begin
        if (count_next < fcc_pkg::MIN_FRAME || count_next != expect_len) begin
            status = fcc_pkg::STATUS_MALFORMED;
        end
        else if (header_next[7:0] != version_reg) begin
            status = fcc_pkg::STATUS_BAD_VERSION;
        end
        else if ((crc_next ^ fcc_pkg::CRC_ONES) != trailer_next) begin
            status = fcc_pkg::STATUS_BAD_CRC;
        end
        else begin
            status = fcc_pkg::STATUS_OK;
        end
    end

    assign res_valid               = advance && in_last_reg;
    assign res_data.status         = status;
    assign res_data.frame_type     = header_next[15:8];
    assign res_data.opcode         = header_next[23:16];
    assign res_data.frame_id       = header_next[31:24];
    assign res_data.payload_length = header_next[47:32];

    // Frame state; cleared after the final byte
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg   <= '0;
            header_reg  <= '0;
            crc_reg     <= fcc_pkg::CRC_ONES;
            trailer_reg <= '0;
        end
        else if (advance) begin
            if (in_last_reg) begin
                count_reg   <= '0;
                header_reg  <= '0;
                crc_reg     <= fcc_pkg::CRC_ONES;
                trailer_reg <= '0;
            end
            else begin
                count_reg   <= count_next;
                header_reg  <= header_next;
                crc_reg     <= crc_next;
                trailer_reg <= trailer_next;
            end
        end
    end

    // CRC stays at its seed until bytes fall out of the trailer window
    a_crc_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= fcc_pkg::TRAILER_LEN) |-> (crc_reg == fcc_pkg::CRC_ONES))
        else $error("CRC moved before trailer window filled");

    // Final byte restarts the frame
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (count_reg == '0 && header_reg == '0))
        else $error("frame state not cleared after final beat");

    // Header bytes beyond the count were never written
    a_header_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < fcc_pkg::HDR_LEN) |-> (header_reg[47:40] == 8'd0))
        else $error("length high byte set before sixth beat");

endmodule

[hdl/fcc_result_buf.sv]
// ----------------------------------------------------------------------------
// fcc_result_buf: two-entry result register with skid slot
// Decouples the output stall from the input side; ready is registered.
// ----------------------------------------------------------------------------
module fcc_result_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  fcc_pkg::result_t push_data,
    output logic             push_ready,
    output logic             pop_valid,
    output fcc_pkg::result_t pop_data,
    input  logic             pop_ready
);

    logic             main_valid_reg;
    fcc_pkg::result_t main_data_reg;
    logic             skid_valid_reg;
    fcc_pkg::result_t skid_data_reg;
    logic             push;
    logic             pop;

    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && pop_ready;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_data_reg;

    // Occupancy
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            if (pop) begin
                main_valid_reg <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end
            else if (push) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= main_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk) begin
        if (pop) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push && !main_valid_reg) begin
            main_data_reg <= push_data;
        end
        if (push && main_valid_reg && !pop) begin
            skid_data_reg <= push_data;
        end
    end

    // Skid slot only fills behind a held main entry
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry without main entry");

    // A full buffer drains by exactly one on a pop
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg))
        else $error("full buffer lost or kept an entry on pop");

    // Beat held back while full is presented next
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !pop) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid entry changed while stalled");

endmodule

[hdl/frame_checker_crc32_top.sv]
// ----------------------------------------------------------------------------
// frame_checker_crc32_top: byte-serial framed packet checker with CRC-32
// Checks header, length, version and reflected CRC-32 of each frame.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one frame byte per beat in s_tdata[7:0]; s_tlast marks the
//   final byte. Frame = version, type, opcode, id, length (LE, 16 bit),
//   payload, CRC-32 (LE) over all earlier bytes.
//   Master stream: one beat per frame, issued for its final byte, carrying
//   status and header fields. Other bytes give no output beat.
//   Config: cfg_wr_en writes cfg_wr_data as the expected version byte;
//   write only while no frame is in flight.
//   Throughput: one byte per cycle unless a final byte waits on a full result
//   buffer; the per-byte CRC update is a combinational 8-bit step.
//   Result path: input register, CRC step and checks, then the result buffer.
//   Reset: expected version returns to 1, frame state clears, no output.
//   Stall: while m_tready is low, two results can be held; once both slots
//   are full, s_tready drops only when another final byte is waiting.
//   Non-final bytes keep flowing.
// ----------------------------------------------------------------------------
module frame_checker_crc32_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [7:0]                        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // data_byte
    input  logic                              s_tlast,   // last_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], frame_type[9:2], opcode[17:10], frame_id[25:18],
    // payload_length[41:26], zero fill
    output logic [fcc_pkg::OutDataWidth-1:0]  m_tdata
);

    logic             res_valid;
    logic             res_ready;
    fcc_pkg::result_t res_data;
    fcc_pkg::result_t out_data;

    // Frame state and checks
    fcc_frame_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_data     (s_tdata),
        .in_last     (s_tlast),
        .in_ready    (s_tready),
        .res_valid   (res_valid),
        .res_data    (res_data),
        .res_ready   (res_ready)
    );

    // Result register
    fcc_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_data  (res_data),
        .push_ready (res_ready),
        .pop_valid  (m_tvalid),
        .pop_data   (out_data),
        .pop_ready  (m_tready)
    );

    assign m_tdata = fcc_pkg::OutDataWidth'(out_data);

endmodule

[tb/frame_checker_crc32_top_tb.sv]
// ----------------------------------------------------------------------------
// frame_checker_crc32_top_tb: self-checking bench for the framed CRC-32 checker
// Builds frames byte by byte (good, short, overlong, wrong length, wrong
// version, corrupted CRC), tracks every accepted byte in a local model of the
// checker and compares each status beat field by field, with random gaps on
// both streams and expected-version writes between frames.
// ----------------------------------------------------------------------------
module frame_checker_crc32_top_tb;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES = 130;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'd0;   // data_byte
    logic s_tlast = 1'b0;         // last_byte
    logic m_tvalid;
    logic m_tready = 1'b0;
    // status[1:0], frame_type[9:2], opcode[17:10], frame_id[25:18],
    // payload_length[41:26], zero fill
    logic [fcc_pkg::OutDataWidth-1:0] m_tdata;

    frame_checker_crc32_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Checker model state
    logic [7:0]                     version_shadow = fcc_pkg::VERSION_RESET;
    logic [fcc_pkg::CountWidth-1:0] frame_count = '0;
    logic [47:0]                    hdr_shadow = '0;
    logic [31:0]                    crc_run = fcc_pkg::CRC_ONES;
    logic [31:0]                    tail_bytes = '0;

    fcc_pkg::result_t expected_status_q[$];
    logic [7:0]       frame_q[$];

    // Bookkeeping
    int  cycles = 0;
    int  mismatches = 0;
    int  frames_sent = 0;
    int  bytes_sent = 0;
    int  beats_checked = 0;
    int  status_seen[4] = '{0, 0, 0, 0};
    bit  tx_gaps = 1'b1;
    bit  rx_gaps = 1'b1;
    fcc_pkg::result_t got_beat;
    fcc_pkg::result_t want_beat;

    // Clock and reset
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Cycle limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver backpressure
    always @(posedge clk) begin
        m_tready <= !rx_gaps || ($urandom_range(0, 99) >= 20);
    end

    // Reflected CRC-32, one byte, data bits taken LSB first
    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ d[i])
                r = (r >> 1) ^ fcc_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // Advance the model by one accepted byte; queue a status on the final one
    task automatic track_byte(input logic [7:0] b, input logic fin);
        logic [fcc_pkg::CountWidth-1:0] seen;
        fcc_pkg::result_t r;
        seen = frame_count;
        if (seen < fcc_pkg::HDR_LEN)
            hdr_shadow[8*int'(seen) +: 8] = b;
        if (seen >= fcc_pkg::TRAILER_LEN)
            crc_run = crc32_step(crc_run, tail_bytes[7:0]);
        tail_bytes = {b, tail_bytes[31:8]};
        if (seen != fcc_pkg::COUNT_MAX)
            frame_count = seen + 1'b1;
        if (fin) begin
            r.frame_type     = hdr_shadow[15:8];
            r.opcode         = hdr_shadow[23:16];
            r.frame_id       = hdr_shadow[31:24];
            r.payload_length = hdr_shadow[47:32];
            if (frame_count < fcc_pkg::MIN_FRAME ||
                frame_count != fcc_pkg::MIN_FRAME + hdr_shadow[47:32])
                r.status = fcc_pkg::STATUS_MALFORMED;
            else if (hdr_shadow[7:0] != version_shadow)
                r.status = fcc_pkg::STATUS_BAD_VERSION;
            else if ((crc_run ^ fcc_pkg::CRC_ONES) != tail_bytes)
                r.status = fcc_pkg::STATUS_BAD_CRC;
            else
                r.status = fcc_pkg::STATUS_OK;
            expected_status_q.push_back(r);
            frame_count = '0;
            hdr_shadow  = '0;
            crc_run     = fcc_pkg::CRC_ONES;
            tail_bytes  = '0;
        end
    endtask

    // Status beat checker
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got_beat = m_tdata[fcc_pkg::ResultWidth-1:0];
            if (expected_status_q.size() == 0) begin
                report_mismatch($sformatf("unexpected status beat 0x%0h", got_beat));
            end
            else begin
                want_beat = expected_status_q.pop_front();
                check_field("status", 16'(got_beat.status), 16'(want_beat.status));
                check_field("frame_type", 16'(got_beat.frame_type), 16'(want_beat.frame_type));
                check_field("opcode", 16'(got_beat.opcode), 16'(want_beat.opcode));
                check_field("frame_id", 16'(got_beat.frame_id), 16'(want_beat.frame_id));
                check_field("payload_length", got_beat.payload_length,
                            want_beat.payload_length);
                status_seen[want_beat.status]++;
            end
            beats_checked++;
        end
    end

    // One byte beat, with optional idle cycles ahead of it
    task automatic send_beat(input logic [7:0] b, input logic fin);
        while (tx_gaps && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_beat(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // Header, n_pay random payload bytes, CRC trailer (one bit flipped if bad)
    task automatic make_frame(input logic [7:0] ver, input logic [7:0] ftype,
                              input logic [7:0] opc, input logic [7:0] fid,
                              input logic [15:0] plen, input int n_pay,
                              input bit crc_ok);
        logic [31:0] c;
        frame_q.delete();
        frame_q.push_back(ver);
        frame_q.push_back(ftype);
        frame_q.push_back(opc);
        frame_q.push_back(fid);
        frame_q.push_back(plen[7:0]);
        frame_q.push_back(plen[15:8]);
        for (int i = 0; i < n_pay; i++)
            frame_q.push_back(8'($urandom));
        c = fcc_pkg::CRC_ONES;
        foreach (frame_q[i])
            c = crc32_step(c, frame_q[i]);
        c = c ^ fcc_pkg::CRC_ONES;
        if (!crc_ok)
            c = c ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++)
            frame_q.push_back(c[8*i +: 8]);
    endtask

    task automatic make_random_frame(input logic [7:0] ver, input logic [15:0] plen,
                                     input int n_pay, input bit crc_ok);
        make_frame(ver, 8'($urandom), 8'($urandom), 8'($urandom), plen, n_pay, crc_ok);
    endtask

    // Stop sending and wait until every queued status has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_version(input logic [7:0] v);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        version_shadow = v;
    endtask

    // Short directed frames against the reset version
    task automatic test_directed();
        // good frame, empty payload
        make_frame(fcc_pkg::VERSION_RESET, 8'hFF, 8'h00, 8'hFF, 16'd0, 0, 1'b1);
        send_frame();
        // corrupted trailer
        make_frame(fcc_pkg::VERSION_RESET, 8'h00, 8'hFF, 8'h00, 16'd0, 0, 1'b0);
        send_frame();
        // single byte frame: nothing of the header beyond the version
        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame();
        // three byte frame: type and opcode only
        frame_q.delete();
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hA5);
        frame_q.push_back(8'h5A);
        send_frame();
    endtask

    // Expected version sweep, including both extremes, and check priority
    task automatic test_version_sweep();
        logic [7:0] settings[4];
        logic [7:0] wrong;
        int n;
        settings = '{8'h00, 8'hFF, 8'($urandom), fcc_pkg::VERSION_RESET};
        foreach (settings[k]) begin
            write_version(settings[k]);
            wrong = settings[k] ^ 8'($urandom_range(1, 255));
            n = $urandom_range(0, 4);
            make_random_frame(settings[k], 16'(n), n, 1'b1);
            send_frame();
            // wrong version only
            make_random_frame(wrong, 16'(n), n, 1'b1);
            send_frame();
            // wrong version and bad trailer: version reported
            make_random_frame(wrong, 16'(n), n, 1'b0);
            send_frame();
            // wrong version and wrong length: malformed reported
            make_random_frame(wrong, 16'(n + 1), n, 1'b0);
            send_frame();
        end
    endtask

    // Length field far above and below the payload, then a good frame, no gaps
    task automatic test_long_frames();
        wait_results_drained();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        // largest length field, short payload
        make_random_frame(version_shadow, 16'hFFFF, 24, 1'b1);
        send_frame();
        // payload runs past the declared length
        make_random_frame(version_shadow, 16'd4, 24, 1'b1);
        send_frame();
        make_random_frame(version_shadow, 16'd24, 24, 1'b1);
        send_frame();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // Mostly well-formed frames with random content, plus damaged ones
    task automatic test_random_frames();
        int start_bytes;
        int kind;
        int n;
        int idx;
        logic [15:0] plen;
        logic [7:0] ver;
        bit crc_ok;
        start_bytes = bytes_sent;
        idx = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            if (idx == 12)
                tx_gaps = 1'b0;
            if (idx == 20) begin
                tx_gaps = 1'b1;
                write_version(8'($urandom));
            end
            kind   = $urandom_range(0, 99);
            n      = $urandom_range(0, 12);
            plen   = 16'(n);
            ver    = version_shadow;
            crc_ok = 1'b1;
            if (kind < 10)
                ver = version_shadow ^ 8'($urandom_range(1, 255));
            else if (kind < 20)
                crc_ok = 1'b0;
            else if (kind < 28)
                plen = plen ^ (16'd1 << $urandom_range(0, 15));
            make_random_frame(ver, plen, n, crc_ok);
            // truncated frame
            if (kind >= 28 && kind < 35) begin
                n = $urandom_range(1, 9);
                while (frame_q.size() > n)
                    void'(frame_q.pop_back());
            end
            // line noise
            if (kind >= 35 && kind < 40) begin
                frame_q.delete();
                n = $urandom_range(1, 30);
                for (int i = 0; i < n; i++)
                    frame_q.push_back(8'($urandom));
            end
            send_frame();
            idx++;
        end
    endtask

    // Test sequence
    initial begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        test_directed();
        test_version_sweep();
        test_random_frames();
        test_long_frames();
        write_version(fcc_pkg::VERSION_RESET);
        test_random_frames();
        wait_results_drained();
        $display("covered %0d frames, %0d bytes, %0d status beats", frames_sent,
                 bytes_sent, beats_checked);
        $display("status mix: ok %0d, malformed %0d, bad version %0d, bad crc %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
